// ===== rtl/core/cron_time_field_parser_defines.svh =====
// assertion macros for the crontab field parser
`ifndef CRON_TIME_FIELD_PARSER_DEFINES_SVH
`define CRON_TIME_FIELD_PARSER_DEFINES_SVH

// same-cycle implication
`define CTFP_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define CTFP_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/ctfp_pkg.sv =====
// ----------------------------------------------------------------------------
// ctfp_pkg
// types, constants and helpers shared by the crontab field parser
// ----------------------------------------------------------------------------
`default_nettype none
package ctfp_pkg;

  localparam int unsigned NumFields = 5;
  localparam int unsigned QDepth    = 2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_start;
  } ctfp_in_t;

  typedef struct packed {
    logic [2:0]  field_index;
    logic [63:0] field_mask;
    logic        status;
  } ctfp_out_t;

  typedef struct packed {
    logic [2:0] field;
    logic [7:0] low;
    logic [7:0] high;
    logic [7:0] step;
    logic       clr;
    logic       fill;
    logic       emit;
    logic       rej;
  } ctfp_cmd_t;

  typedef enum logic [2:0] {
    PH_FIELD, PH_ITEM, PH_LOW, PH_STAR, PH_HIGH, PH_STEP
  } ctfp_phase_t;

  typedef enum logic [1:0] {
    B_IDLE, B_WALK, B_EMIT
  } ctfp_bstate_t;

  function automatic logic [2:0] fidx(input logic [2:0] f);
    return (f < 3'(NumFields)) ? f : 3'(NumFields - 1);
  endfunction

  function automatic logic [7:0] field_min(input logic [2:0] f);
    return (fidx(f) == 3'd3) ? 8'd1 : 8'd0;
  endfunction

  function automatic logic [7:0] field_max(input logic [2:0] f);
    logic [7:0] m;
    unique case (fidx(f))
      3'd0:    m = 8'd59;
      3'd1:    m = 8'd23;
      3'd2:    m = 8'd31;
      3'd3:    m = 8'd12;
      default: m = 8'd7;
    endcase
    return m;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c == 8'd9) || ((c >= 8'd10) && (c <= 8'd13));
  endfunction

  function automatic logic [7:0] add_digit(input logic [7:0] v, input logic [3:0] d);
    logic [11:0] n;
    n = 12'(v) * 12'd10 + 12'(d);
    return (n > 12'd255) ? 8'd255 : n[7:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cron_time_field_parser.sv =====
// ----------------------------------------------------------------------------
// cron_time_field_parser
// parses the five time fields of a crontab line into per-field bit masks
// ----------------------------------------------------------------------------
// The classifier takes one text byte per cycle and hands each finished list
// item to a two-entry queue; the mask builder drains it, setting one mask bit
// per cycle. Byte intake stalls only while the queue is full, so long stepped
// ranges such as 0-59 set the sustained rate.
`default_nettype none
module cron_time_field_parser import ctfp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ctfp_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output ctfp_out_t      out_data
);

  logic      q_push, q_pop, q_full, q_empty;
  ctfp_cmd_t q_cmd, q_head;

  ctfp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_full, .q_push, .q_cmd
  );

  ctfp_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_cmd(q_cmd), .pop(q_pop),
    .full(q_full), .empty(q_empty), .head(q_head)
  );

  ctfp_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .q_pop,
    .out_valid, .out_stall, .out_data
  );

endmodule
`default_nettype wire

// ===== rtl/core/ctfp_front.sv =====
// ----------------------------------------------------------------------------
// ctfp_front
// byte classifier: tracks the field grammar and issues fill and emit commands
// ----------------------------------------------------------------------------
`default_nettype none
module ctfp_front import ctfp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ctfp_in_t  in_data,
  input  wire logic      q_full,
  output logic           q_push,
  output ctfp_cmd_t      q_cmd
);

  logic [2:0]  field_r, field_nxt;
  ctfp_phase_t phase_r, phase_nxt;
  logic [7:0]  low_r, low_nxt, high_r, high_nxt, step_r, step_nxt;
  logic        ds_r, ds_nxt, locked_r, locked_nxt, pclr_r, pclr_nxt;

  logic       acc;
  logic [7:0] c;
  logic       dig;
  logic [3:0] d;
  logic       fin;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign c        = in_data.text_byte;
  assign dig      = (c >= 8'h30) && (c <= 8'h39);
  assign d        = dig ? 4'(c - 8'h30) : 4'd0;

  always_comb begin
    field_nxt  = field_r;
    phase_nxt  = phase_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    step_nxt   = step_r;
    ds_nxt     = ds_r;
    locked_nxt = locked_r;
    pclr_nxt   = pclr_r;
    fin        = 1'b0;
    q_push     = 1'b0;
    q_cmd      = '0;
    if (in_data.line_start) begin
      field_nxt  = '0;
      phase_nxt  = PH_FIELD;
      low_nxt    = '0;
      high_nxt   = '0;
      step_nxt   = '0;
      ds_nxt     = 1'b0;
      locked_nxt = 1'b0;
      pclr_nxt   = 1'b1;
    end
    q_cmd.field = field_nxt;
    q_cmd.clr   = pclr_nxt;
    if (!locked_nxt) begin
      unique case (phase_nxt)
        PH_FIELD, PH_ITEM: begin
          if (dig) begin
            low_nxt   = 8'(d);
            ds_nxt    = 1'b1;
            phase_nxt = PH_LOW;
          end else if (c == 8'h2a) begin
            low_nxt   = field_min(field_nxt);
            high_nxt  = field_max(field_nxt);
            phase_nxt = PH_STAR;
          end else if (!(is_ws(c) && phase_nxt == PH_FIELD)) begin
            q_cmd.rej = 1'b1;
          end
        end
        PH_LOW: begin
          if (dig) begin
            low_nxt = add_digit(low_nxt, d);
          end else if (low_nxt < field_min(field_nxt) || low_nxt > field_max(field_nxt)) begin
            q_cmd.rej = 1'b1;
          end else if (c == 8'h2d) begin
            phase_nxt = PH_HIGH;
            high_nxt  = '0;
            ds_nxt    = 1'b0;
          end else if (c == 8'h2f) begin
            high_nxt  = low_nxt;
            phase_nxt = PH_STEP;
            step_nxt  = '0;
            ds_nxt    = 1'b0;
          end else begin
            high_nxt = low_nxt;
            step_nxt = 8'd1;
            fin      = 1'b1;
          end
        end
        PH_STAR: begin
          if (c == 8'h2f) begin
            phase_nxt = PH_STEP;
            step_nxt  = '0;
            ds_nxt    = 1'b0;
          end else begin
            step_nxt = 8'd1;
            fin      = 1'b1;
          end
        end
        PH_HIGH: begin
          if (dig) begin
            high_nxt = add_digit(high_nxt, d);
            ds_nxt   = 1'b1;
          end else if (!ds_nxt || high_nxt < field_min(field_nxt) ||
                       high_nxt > field_max(field_nxt)) begin
            q_cmd.rej = 1'b1;
          end else if (c == 8'h2f) begin
            phase_nxt = PH_STEP;
            step_nxt  = '0;
            ds_nxt    = 1'b0;
          end else begin
            step_nxt = 8'd1;
            fin      = 1'b1;
          end
        end
        PH_STEP: begin
          if (dig) begin
            step_nxt = add_digit(step_nxt, d);
            ds_nxt   = 1'b1;
          end else if (!ds_nxt) begin
            q_cmd.rej = 1'b1;
          end else begin
            if (step_nxt == 8'd0) step_nxt = 8'd1;
            fin = 1'b1;
          end
        end
        default: q_cmd.rej = 1'b1;
      endcase
      if (fin) begin
        if (c != 8'h2c && !is_ws(c)) begin
          q_cmd.rej = 1'b1;
        end else begin
          q_cmd.fill = 1'b1;
          q_cmd.low  = low_nxt;
          q_cmd.high = high_nxt;
          q_cmd.step = step_nxt;
          low_nxt    = '0;
          high_nxt   = '0;
          step_nxt   = '0;
          ds_nxt     = 1'b0;
          if (c == 8'h2c) begin
            phase_nxt = PH_ITEM;
          end else begin
            q_cmd.emit = 1'b1;
            if (field_nxt >= 3'(NumFields - 1)) begin
              locked_nxt = 1'b1;
            end else begin
              field_nxt = field_nxt + 3'd1;
              phase_nxt = PH_FIELD;
            end
          end
        end
      end
      if (q_cmd.rej) begin
        q_cmd.emit = 1'b1;
        q_cmd.fill = 1'b0;
        locked_nxt = 1'b1;
      end
      q_push = acc && (q_cmd.emit || q_cmd.fill);
      if (q_cmd.emit || q_cmd.fill) pclr_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r  <= '0;
      phase_r  <= PH_FIELD;
      low_r    <= '0;
      high_r   <= '0;
      step_r   <= '0;
      ds_r     <= 1'b0;
      locked_r <= 1'b1;
      pclr_r   <= 1'b1;
    end else if (acc) begin
      field_r  <= field_nxt;
      phase_r  <= phase_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      step_r   <= step_nxt;
      ds_r     <= ds_nxt;
      locked_r <= locked_nxt;
      pclr_r   <= pclr_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ctfp_queue.sv =====
// ----------------------------------------------------------------------------
// ctfp_queue
// two-entry command queue between the classifier and the mask builder
// ----------------------------------------------------------------------------
`default_nettype none
module ctfp_queue import ctfp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire ctfp_cmd_t push_cmd,
  input  wire logic      pop,
  output logic           full,
  output logic           empty,
  output ctfp_cmd_t      head
);

  localparam int unsigned PtrW = $clog2(QDepth);

  ctfp_cmd_t         mem_r [QDepth];
  logic [PtrW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PtrW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (PtrW+1)'(QDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? PtrW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = pop  ? PtrW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
  end

endmodule
`default_nettype wire

// ===== rtl/core/ctfp_back.sv =====
// ----------------------------------------------------------------------------
// ctfp_back
// mask builder: walks each range one value per cycle and emits field results
// ----------------------------------------------------------------------------
`default_nettype none
module ctfp_back import ctfp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_empty,
  input  wire ctfp_cmd_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output ctfp_out_t      out_data
);

  ctfp_bstate_t st_r, st_nxt;
  logic [63:0]  acc_r, acc_nxt;
  logic [8:0]   v_r, v_nxt;
  logic [7:0]   hi_r, hi_nxt, stp_r, stp_nxt;
  logic [2:0]   fld_r, fld_nxt;
  logic         emit_r, emit_nxt, rej_r, rej_nxt;
  logic         ov_r, ov_nxt;
  ctfp_out_t    od_r, od_nxt;
  logic [5:0]   bidx;

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign bidx      = (fidx(fld_r) == 3'd4 && v_r == 9'd0) ? 6'd7 : v_r[5:0];

  always_comb begin
    st_nxt   = st_r;
    acc_nxt  = acc_r;
    v_nxt    = v_r;
    hi_nxt   = hi_r;
    stp_nxt  = stp_r;
    fld_nxt  = fld_r;
    emit_nxt = emit_r;
    rej_nxt  = rej_r;
    ov_nxt   = ov_r && out_stall;
    od_nxt   = od_r;
    q_pop    = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          if (q_head.clr) acc_nxt = '0;
          v_nxt    = 9'(q_head.low);
          hi_nxt   = q_head.high;
          stp_nxt  = q_head.step;
          fld_nxt  = q_head.field;
          emit_nxt = q_head.emit;
          rej_nxt  = q_head.rej;
          st_nxt   = q_head.fill ? B_WALK : B_EMIT;
        end
      end
      B_WALK: begin
        if (v_r <= 9'(hi_r)) begin
          acc_nxt[bidx] = 1'b1;
          v_nxt = v_r + 9'(stp_r);
        end else begin
          st_nxt = emit_r ? B_EMIT : B_IDLE;
        end
      end
      B_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt             = 1'b1;
          od_nxt.field_index = fld_r;
          od_nxt.field_mask  = rej_r ? 64'd0 : acc_r;
          od_nxt.status      = rej_r;
          acc_nxt            = '0;
          st_nxt             = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_IDLE;
      ov_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      st_r  <= st_nxt;
      ov_r  <= ov_nxt;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    hi_r   <= hi_nxt;
    stp_r  <= stp_nxt;
    fld_r  <= fld_nxt;
    emit_r <= emit_nxt;
    rej_r  <= rej_nxt;
    od_r   <= od_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/ctfp_checker.sv =====
// ----------------------------------------------------------------------------
// ctfp_checker
// port-level checks for the crontab field parser
// ----------------------------------------------------------------------------
`default_nettype none
`include "cron_time_field_parser_defines.svh"
module ctfp_checker import ctfp_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire ctfp_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire ctfp_out_t out_data
);

  `CTFP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `CTFP_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  `CTFP_ASSERT_IMP(a_rej_zero, out_valid && out_data.status, out_data.field_mask == 64'd0)
  `CTFP_ASSERT_IMP(a_idx_range, out_valid, out_data.field_index <= 3'(NumFields - 1))

endmodule

bind cron_time_field_parser ctfp_checker u_ctfp_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
);
`default_nettype wire

// ===== bench/cron_time_field_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cron_time_field_checker
// watches both channels of the crontab field parser, predicts each field
// mask or rejection from the accepted bytes and compares in arrival order
// ----------------------------------------------------------------------------
module cron_time_field_checker import ctfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  ctfp_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  ctfp_out_t out_data,
  output int        fail_count,
  output int        pending
);

  logic [2:0]  cur_field;
  ctfp_phase_t phase;
  logic [7:0]  lo_val, hi_val, step_val;
  logic        got_digit;
  logic [63:0] mask_acc;
  logic        locked;
  ctfp_out_t   mask_q[$];

  assign pending = mask_q.size();

  function automatic logic [2:0] fsel();
    return (cur_field < 3'd5) ? cur_field : 3'd4;
  endfunction

  function automatic logic [7:0] fmin();
    return (fsel() == 3'd3) ? 8'd1 : 8'd0;
  endfunction

  function automatic logic [7:0] fmax();
    case (fsel())
      3'd0: return 8'd59;
      3'd1: return 8'd23;
      3'd2: return 8'd31;
      3'd3: return 8'd12;
      default: return 8'd7;
    endcase
  endfunction

  function automatic logic white(logic [7:0] c);
    return c == 8'd32 || c == 8'd9 || (c >= 8'd10 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] accum(logic [7:0] v, logic [7:0] d);
    int n;
    n = int'(v) * 10 + int'(d);
    return (n > 255) ? 8'd255 : 8'(n);
  endfunction

  task automatic reject_line();
    ctfp_out_t r;
    r.field_index = cur_field;
    r.field_mask = '0;
    r.status = 1'b1;
    mask_q.push_back(r);
    locked = 1'b1;
  endtask

  task automatic close_item(logic [7:0] c);
    int v, st, b;
    ctfp_out_t r;
    if (c != ",") begin
      if (!white(c)) begin
        reject_line();
        return;
      end
    end
    st = (step_val != 0) ? int'(step_val) : 1;
    for (v = lo_val; v <= hi_val; v += st) begin
      b = (fsel() == 3'd4 && v == 0) ? 7 : v;
      if (b < 64) mask_acc[b] = 1'b1;
    end
    lo_val = 0; hi_val = 0; step_val = 0; got_digit = 0;
    if (c == ",") begin
      phase = PH_ITEM;
      return;
    end
    r.field_index = cur_field;
    r.field_mask = mask_acc;
    r.status = 1'b0;
    mask_q.push_back(r);
    if (cur_field >= 3'd4) begin
      locked = 1'b1;
    end else begin
      cur_field++;
      mask_acc = '0;
      phase = PH_FIELD;
    end
  endtask

  task automatic parse_byte(ctfp_in_t it);
    logic [7:0] c;
    logic dig;
    logic [7:0] d;
    c = it.text_byte;
    dig = c >= "0" && c <= "9";
    d = dig ? c - 8'd48 : 8'd0;
    if (it.line_start) begin
      cur_field = 0; phase = PH_FIELD; lo_val = 0; hi_val = 0; step_val = 0;
      got_digit = 0; mask_acc = '0; locked = 0;
    end
    if (locked) return;
    case (phase)
      PH_FIELD, PH_ITEM: begin
        if (dig) begin
          lo_val = d; got_digit = 1; phase = PH_LOW;
        end else if (c == "*") begin
          lo_val = fmin(); hi_val = fmax(); phase = PH_STAR;
        end else if (!(white(c) && phase == PH_FIELD)) begin
          reject_line();
        end
      end
      PH_LOW: begin
        if (dig) begin
          lo_val = accum(lo_val, d);
        end else if (lo_val < fmin() || lo_val > fmax()) begin
          reject_line();
        end else if (c == "-") begin
          phase = PH_HIGH; hi_val = 0; got_digit = 0;
        end else begin
          hi_val = lo_val;
          if (c == "/") begin
            phase = PH_STEP; step_val = 0; got_digit = 0;
          end else begin
            step_val = 1; close_item(c);
          end
        end
      end
      PH_STAR: begin
        if (c == "/") begin
          phase = PH_STEP; step_val = 0; got_digit = 0;
        end else begin
          step_val = 1; close_item(c);
        end
      end
      PH_HIGH: begin
        if (dig) begin
          hi_val = accum(hi_val, d); got_digit = 1;
        end else if (!got_digit || hi_val < fmin() || hi_val > fmax()) begin
          reject_line();
        end else if (c == "/") begin
          phase = PH_STEP; step_val = 0; got_digit = 0;
        end else begin
          step_val = 1; close_item(c);
        end
      end
      PH_STEP: begin
        if (dig) begin
          step_val = accum(step_val, d); got_digit = 1;
        end else if (!got_digit) begin
          reject_line();
        end else begin
          if (step_val == 0) step_val = 1;
          close_item(c);
        end
      end
      default: reject_line();
    endcase
  endtask

  initial begin
    fail_count = 0;
    cur_field = 0; phase = PH_FIELD; lo_val = 0; hi_val = 0; step_val = 0;
    got_digit = 0; mask_acc = '0; locked = 1;
  end

  always @(posedge clk) begin
    ctfp_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (mask_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = mask_q.pop_front();
          if (want.field_index !== out_data.field_index ||
              want.field_mask !== out_data.field_mask ||
              want.status !== out_data.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p got %p", want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) parse_byte(in_data);
    end
  end

endmodule

// ===== bench/tb_cron_time_field_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cron_time_field_parser
// feeds crontab lines, well formed and broken, byte by byte with random gaps
// and receiver stalls; a separate checker predicts and compares the results
// ----------------------------------------------------------------------------
module tb_cron_time_field_parser import ctfp_pkg::*;;

  localparam int WatchLimit = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  ctfp_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ctfp_out_t out_data;
  int        fail_count;
  int        pending;
  int        idle_cycles = 0;
  logic      stall_on = 1'b1;
  int        hold_cnt = 0;
  byte unsigned line_buf[$];
  int        n_sent = 0;

  always #1 clk = ~clk;

  cron_time_field_parser i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  cron_time_field_checker i_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // receiver stalls, with stretches of none and a few long holds
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;
    if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) == 0) begin
      hold_cnt  <= $urandom_range(10, 40);
      out_stall <= 1'b1;
    end else begin
      out_stall <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(byte unsigned c, logic first);
    int g;
    ctfp_in_t it;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    it.text_byte  = c;
    it.line_start = first;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic send_line(string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k], k == 0);
  endtask

  function automatic string rnd_num(int lo, int hi);
    int r;
    r = $urandom_range(0, 29);
    if (r == 0) return $sformatf("%0d", $urandom_range(0, 300));
    if (r == 1) return $sformatf("00%0d", $urandom_range(lo, hi));
    return $sformatf("%0d", $urandom_range(lo, hi));
  endfunction

  function automatic string rnd_item(int lo, int hi);
    string s;
    case ($urandom_range(0, 5))
      0: s = "*";
      1: s = rnd_num(lo, hi);
      default: s = {rnd_num(lo, hi), "-", rnd_num(lo, hi)};
    endcase
    if ($urandom_range(0, 2) == 0) s = {s, "/", $sformatf("%0d", $urandom_range(0, 70))};
    return s;
  endfunction

  function automatic string rnd_ws();
    case ($urandom_range(0, 5))
      0: return "\t";
      1: return "  ";
      2: return "\n";
      3: return "\r";
      default: return " ";
    endcase
  endfunction

  function automatic string rnd_line();
    int lo[5] = '{0, 0, 0, 1, 0};
    int hi[5] = '{59, 23, 31, 12, 7};
    string s;
    int nf;
    s = ($urandom_range(0, 4) == 0) ? " " : "";
    nf = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 5;
    for (int f = 0; f < nf; f++) begin
      s = {s, rnd_item(lo[f], hi[f])};
      repeat ($urandom_range(0, 2)) s = {s, ",", rnd_item(lo[f], hi[f])};
      s = {s, rnd_ws()};
    end
    if (nf == 5) s = {s, "cmd x"};
    return s;
  endfunction

  initial begin
    string s;
    int p;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    // bytes before any line start are ignored
    send_byte("5", 1'b0);
    send_byte(" ", 1'b0);
    send_line("0 0 0 1 0 x");
    send_line(" 59 23 31 12 7 ");
    send_line("*/0 */5 1-31/7 *,1 0-7/2\t");
    send_line("5/3 20-3 31 1-12/255 0,7\r");
    send_line("1, 2");
    send_line("60 1");
    send_line("0 0 0 0 ");
    send_line("1- 2");
    send_line("*/ 1");
    send_line("#c");
    send_line("9999 ");
    send_line("1 2 3");
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b1);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    while (n_sent < 1700) begin
      case ($urandom_range(0, 9))
        0: begin
          s = "";
          repeat ($urandom_range(1, 8)) s = {s, string'(byte'($urandom_range(0, 255)))};
          send_line(s);
        end
        1: begin
          s = rnd_line();
          p = $urandom_range(0, s.len() - 1);
          s[p] = byte'($urandom_range(0, 255));
          send_line(s);
        end
        default: send_line(rnd_line());
      endcase
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
